### src/gcb_pkg.sv
// Shared types, constants and helpers for the glyph coverage blitter.
`default_nettype none
package gcb_pkg;

  localparam int MAX_GLYPH_SIZE = 256;
  localparam int MAX_FRAME_DIM  = 4096;

  // Fixed field and register widths
  localparam int COLOR_W    = 16;
  localparam int FRAME_W    = 13;
  localparam int STRIDE_W   = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int COV_W      = 8;
  localparam int ORIGIN_W   = 16;
  localparam int GWIDTH_W   = 9;
  localparam int OFFSET_W   = 26;
  localparam int ALPHA_W    = 4;

  // Derived widths
  localparam int CNT_W     = $clog2(MAX_GLYPH_SIZE);
  localparam int COORD_W   = $clog2(MAX_FRAME_DIM);
  localparam int POS_W     = ORIGIN_W + 1;
  localparam int CMP_W     = (CNT_W + 1 > GWIDTH_W) ? CNT_W + 1 : GWIDTH_W;
  localparam int DIM_W     = (FRAME_W > COORD_W + 1) ? FRAME_W : COORD_W + 1;
  localparam int PROD_W    = ALPHA_W + COV_W;

  localparam int Q_DEPTH   = 4;
  localparam int Q_IDX_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [COLOR_W-1:0] RGB_MASK   = 16'hFFF0;
  localparam logic [COLOR_W-1:0] ALPHA_MASK = 16'h000F;

  localparam logic [COLOR_W-1:0]  TEXT_COLOR_RST   = 16'hFFFF;
  localparam logic [FRAME_W-1:0]  FRAME_WIDTH_RST  = 13'd1280;
  localparam logic [FRAME_W-1:0]  FRAME_HEIGHT_RST = 13'd720;
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST   = 15'd2560;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COLOR   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2,
    CFG_ROW_STRIDE   = 2'd3
  } cfg_idx_t;

  // One pixel write waiting for its address
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [ALPHA_W-1:0] alpha;
  } pix_entry_t;

  // Clamp a frame dimension register to the largest supported frame
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [FRAME_W-1:0] d);
    logic [DIM_W-1:0] de;
    de = DIM_W'(d);
    clamp_dim = (de > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : de;
  endfunction

  // floor(p / 255) by reciprocal: exact for any 12-bit p
  function automatic logic [ALPHA_W-1:0] div255(input logic [PROD_W-1:0] p);
    logic [PROD_W+1:0] p1;
    logic [PROD_W+1:0] s;
    p1 = (PROD_W+2)'(p) + (PROD_W+2)'(1);
    s  = p1 + (p1 >> 8);
    div255 = ALPHA_W'(s >> 8);
  endfunction

endpackage
`default_nettype wire

### src/gcb_front.sv
// Front end: glyph counters, clipping and alpha scaling of each coverage byte.
`default_nettype none
module gcb_front import gcb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [COV_W-1:0]    coverage,
  input  wire logic [ORIGIN_W-1:0] origin_x,
  input  wire logic [ORIGIN_W-1:0] origin_y,
  input  wire logic [GWIDTH_W-1:0] glyph_width,
  input  wire logic                glyph_end,
  input  wire logic [COLOR_W-1:0]  text_color,
  input  wire logic [FRAME_W-1:0]  frame_width,
  input  wire logic [FRAME_W-1:0]  frame_height,
  output logic                     push,
  output pix_entry_t               entry
);

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;

  logic signed [POS_W-1:0] fx, fy;
  logic [DIM_W-1:0]        fw, fh;
  logic                    in_frame;
  logic [PROD_W-1:0]       prod;
  logic [ALPHA_W-1:0]      alpha;
  logic [CMP_W-1:0]        gw_ext, gw_eff, col_inc;

  always_comb begin
    fx = POS_W'($signed(origin_x)) + $signed(POS_W'(col_r));
    fy = POS_W'($signed(origin_y)) + $signed(POS_W'(row_r));
    fw = clamp_dim(frame_width);
    fh = clamp_dim(frame_height);
    in_frame = !fx[POS_W-1] && !fy[POS_W-1]
               && (POS_W'(fx) < POS_W'(fw)) && (POS_W'(fy) < POS_W'(fh));
    prod  = PROD_W'(text_color[ALPHA_W-1:0]) * PROD_W'(coverage);
    alpha = div255(prod);
    push  = accept && in_frame && (coverage != '0) && (alpha != '0);
    entry.px    = fx[COORD_W-1:0];
    entry.py    = fy[COORD_W-1:0];
    entry.alpha = alpha;
  end

  // Column wraps at the effective glyph width, row saturates; glyph end clears both
  always_comb begin
    gw_ext = CMP_W'(glyph_width);
    priority if (gw_ext == '0) begin
      gw_eff = CMP_W'(1);
    end else if (gw_ext > CMP_W'(MAX_GLYPH_SIZE)) begin
      gw_eff = CMP_W'(MAX_GLYPH_SIZE);
    end else begin
      gw_eff = gw_ext;
    end
    col_inc = CMP_W'(col_r) + CMP_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      priority if (glyph_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= gw_eff) begin
        col_nxt = '0;
        if (row_r < CNT_W'(MAX_GLYPH_SIZE - 1)) begin
          row_nxt = row_r + CNT_W'(1);
        end
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

### src/gcb_queue.sv
// Short queue of pixel writes between the front end and the address stage.
`default_nettype none
module gcb_queue import gcb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire pix_entry_t push_data,
  input  wire logic  pop,
  output pix_entry_t head,
  output logic       not_empty,
  output logic       full
);

  pix_entry_t          mem_r [Q_DEPTH];
  logic [Q_IDX_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    not_empty  = (count_r != '0);
    full       = (count_r == Q_CNT_W'(Q_DEPTH));
    head       = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + Q_IDX_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_IDX_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### src/gcb_back.sv
// Back end: framebuffer address and pixel formation into the output register.
`default_nettype none
module gcb_back import gcb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pix_entry_t          head,
  input  wire logic                head_valid,
  output logic                     pop,
  input  wire logic [COLOR_W-1:0]  text_color,
  input  wire logic [STRIDE_W-1:0] row_stride_bytes,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [OFFSET_W-1:0]      out_write_offset,
  output logic [COLOR_W-1:0]       out_pixel_value
);

  localparam int MUL_W = COORD_W + STRIDE_W;
  localparam int SUM_W = (MUL_W > COORD_W + 1) ? MUL_W + 1 : COORD_W + 2;

  logic                valid_r, valid_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [COLOR_W-1:0]  pixel_r, pixel_nxt;
  logic [MUL_W-1:0]    row_base;
  logic [SUM_W-1:0]    offset_full;

  always_comb begin
    // Load when the output register is free or being taken this cycle
    pop         = head_valid && (!valid_r || !out_stall);
    row_base    = MUL_W'(head.py) * MUL_W'(row_stride_bytes);
    offset_full = SUM_W'(row_base) + (SUM_W'(head.px) << 1);
    offset_nxt  = offset_full[OFFSET_W-1:0];
    pixel_nxt   = (text_color & RGB_MASK) | (COLOR_W'(head.alpha) & ALPHA_MASK);
    priority if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      offset_r <= offset_nxt;
      pixel_r  <= pixel_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_write_offset = offset_r;
  assign out_pixel_value  = pixel_r;

endmodule
`default_nettype wire

### src/glyph_coverage_blitter_unit.sv
// Top level of the glyph coverage blitter: configuration registers and wiring.
//
// Coverage bytes of a glyph enter on the in_ channel, one per transfer, in
// row-major order, each with the glyph origin, width and an end-of-glyph mark.
// Each byte that lands inside the frame with a non-zero scaled alpha gives one
// transfer on the out_ channel: an RGBA4444 pixel and its framebuffer byte
// offset. Bytes that are clipped or fully transparent give nothing.
// Throughput is one byte per cycle while in_stall is low. The accepting edge
// writes each result into the four-entry pixel queue; from there it passes
// through the stride multiplier into the output register, where it is
// presented.
// While out_stall is high the queue and output register buffer up to five
// results; in_stall rises only when the queue is full.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wr_data;
// the user must do so only while the block is idle, which the block itself does
// not enforce. Synchronous reset (rst_n low) restores the register defaults,
// clears the glyph counters and empties the queue and output register.
`default_nettype none
module glyph_coverage_blitter_unit import gcb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COV_W-1:0]      in_coverage,
  input  wire logic [ORIGIN_W-1:0]   in_origin_x,
  input  wire logic [ORIGIN_W-1:0]   in_origin_y,
  input  wire logic [GWIDTH_W-1:0]   in_glyph_width,
  input  wire logic                  in_glyph_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OFFSET_W-1:0]        out_write_offset,
  output logic [COLOR_W-1:0]         out_pixel_value
);

  logic [COLOR_W-1:0]  text_color_r, text_color_nxt;
  logic [FRAME_W-1:0]  frame_width_r, frame_width_nxt;
  logic [FRAME_W-1:0]  frame_height_r, frame_height_nxt;
  logic [STRIDE_W-1:0] row_stride_r, row_stride_nxt;

  logic       in_accept;
  logic       q_push, q_pop, q_not_empty, q_full;
  pix_entry_t q_in, q_head;

  always_comb begin
    text_color_nxt   = text_color_r;
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    row_stride_nxt   = row_stride_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEXT_COLOR:   text_color_nxt   = cfg_wr_data[COLOR_W-1:0];
        CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_wr_data[FRAME_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_nxt = cfg_wr_data[FRAME_W-1:0];
        CFG_ROW_STRIDE:   row_stride_nxt   = cfg_wr_data[STRIDE_W-1:0];
        default:          text_color_nxt   = text_color_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r   <= TEXT_COLOR_RST;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      row_stride_r   <= ROW_STRIDE_RST;
    end else begin
      text_color_r   <= text_color_nxt;
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      row_stride_r   <= row_stride_nxt;
    end
  end

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  gcb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .coverage     (in_coverage),
    .origin_x     (in_origin_x),
    .origin_y     (in_origin_y),
    .glyph_width  (in_glyph_width),
    .glyph_end    (in_glyph_end),
    .text_color   (text_color_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .push         (q_push),
    .entry        (q_in)
  );

  gcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  gcb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .head_valid       (q_not_empty),
    .pop              (q_pop),
    .text_color       (text_color_r),
    .row_stride_bytes (row_stride_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_offset (out_write_offset),
    .out_pixel_value  (out_pixel_value)
  );

endmodule
`default_nettype wire

### sim/gcb_write_checker.sv
`timescale 1ns / 1ps
// Checker for the glyph coverage blitter: predicts every pixel write and compares transfers.
module gcb_write_checker
  import gcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [COV_W-1:0]      in_coverage,
  input  logic [ORIGIN_W-1:0]   in_origin_x,
  input  logic [ORIGIN_W-1:0]   in_origin_y,
  input  logic [GWIDTH_W-1:0]   in_glyph_width,
  input  logic                  in_glyph_end,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [OFFSET_W-1:0]   out_write_offset,
  input  logic [COLOR_W-1:0]    out_pixel_value,
  output int                    fail_count,
  output int                    writes_outstanding
);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [COLOR_W-1:0]  pixel;
  } pixel_write_t;

  logic [COLOR_W-1:0]  text_color;
  logic [FRAME_W-1:0]  frame_w;
  logic [FRAME_W-1:0]  frame_h;
  logic [STRIDE_W-1:0] row_stride;
  int                  column_pos;
  int                  row_pos;
  pixel_write_t        pending_writes[$];

  initial begin
    fail_count = 0;
    writes_outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Work out the write caused by one coverage byte, then advance the glyph counters
  task automatic blit_byte(input logic [COV_W-1:0] cov, input logic [ORIGIN_W-1:0] ox,
                           input logic [ORIGIN_W-1:0] oy, input logic [GWIDTH_W-1:0] gw,
                           input logic last);
    int           px;
    int           py;
    int           fw;
    int           fh;
    int           alpha;
    int           span;
    longint       offs;
    pixel_write_t w;
    px = int'($signed(ox)) + column_pos;
    py = int'($signed(oy)) + row_pos;
    fw = (frame_w > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(frame_w);
    fh = (frame_h > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(frame_h);
    if (px >= 0 && px < fw && py >= 0 && py < fh && cov != 0) begin
      alpha = int'(text_color[ALPHA_W-1:0]) * int'(cov) / 255;
      if (alpha != 0) begin
        offs = longint'(py) * longint'(row_stride) + 2 * longint'(px);
        w.offset = offs[OFFSET_W-1:0];
        w.pixel = {text_color[COLOR_W-1:ALPHA_W], alpha[ALPHA_W-1:0]};
        pending_writes.push_back(w);
      end
    end
    span = (gw == 0) ? 1 : ((gw > MAX_GLYPH_SIZE) ? MAX_GLYPH_SIZE : int'(gw));
    if (last) begin
      column_pos = 0;
      row_pos = 0;
    end else if (column_pos + 1 >= span) begin
      column_pos = 0;
      if (row_pos < MAX_GLYPH_SIZE - 1) row_pos++;
    end else begin
      column_pos++;
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_write_t want;
    if (!rst_n) begin
      text_color = TEXT_COLOR_RST;
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      row_stride = ROW_STRIDE_RST;
      column_pos = 0;
      row_pos = 0;
      pending_writes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEXT_COLOR:   text_color = cfg_wr_data[COLOR_W-1:0];
          CFG_FRAME_WIDTH:  frame_w = cfg_wr_data[FRAME_W-1:0];
          CFG_FRAME_HEIGHT: frame_h = cfg_wr_data[FRAME_W-1:0];
          CFG_ROW_STRIDE:   row_stride = cfg_wr_data[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("write with nothing expected: offset %h pixel %h",
                                    out_write_offset, out_pixel_value));
        end else begin
          want = pending_writes.pop_front();
          if (out_write_offset !== want.offset)
            report_mismatch($sformatf("offset %h, expected %h", out_write_offset,
                                      want.offset));
          if (out_pixel_value !== want.pixel)
            report_mismatch($sformatf("pixel %h, expected %h", out_pixel_value,
                                      want.pixel));
        end
      end
      if (in_valid && !in_stall)
        blit_byte(in_coverage, in_origin_x, in_origin_y, in_glyph_width, in_glyph_end);
    end
    writes_outstanding <= pending_writes.size();
  end

endmodule

### sim/tb_glyph_coverage_blitter_unit.sv
`timescale 1ns / 1ps
// Testbench top for the glyph coverage blitter: clock, reset, stimulus and verdict.
module tb_glyph_coverage_blitter_unit;
  import gcb_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int NUM_PHASES     = 12;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TEXT_COLOR;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COV_W-1:0]      in_coverage = '0;
  logic [ORIGIN_W-1:0]   in_origin_x = '0;
  logic [ORIGIN_W-1:0]   in_origin_y = '0;
  logic [GWIDTH_W-1:0]   in_glyph_width = 9'd1;
  logic                  in_glyph_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OFFSET_W-1:0]   out_write_offset;
  logic [COLOR_W-1:0]    out_pixel_value;

  int fail_count;
  int writes_outstanding;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_trigger = 1'b0;
  // Frame size as the block sees it, used only to aim origins at the frame
  int span_x = 1280;
  int span_y = 720;

  glyph_coverage_blitter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_coverage(in_coverage),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_glyph_width(in_glyph_width), .in_glyph_end(in_glyph_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_write_offset(out_write_offset), .out_pixel_value(out_pixel_value)
  );

  gcb_write_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_coverage(in_coverage),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_glyph_width(in_glyph_width), .in_glyph_end(in_glyph_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_write_offset(out_write_offset), .out_pixel_value(out_pixel_value),
    .fail_count(fail_count), .writes_outstanding(writes_outstanding)
  );

  always #4 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 22);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_glyph_coverage_blitter_unit NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [COV_W-1:0] pick_coverage();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return 8'd0;
    if (sel < 30) return 8'd255;
    if (sel < 35) return 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly just around the frame, now and then anywhere in the 16-bit range
  function automatic logic [ORIGIN_W-1:0] pick_origin(input int span);
    int v;
    if ($urandom_range(0, 99) < 10) return 16'($urandom);
    v = int'($urandom_range(0, span + 20)) - 12;
    return v[ORIGIN_W-1:0];
  endfunction

  // Offer one byte and hold it until the transfer
  task automatic offer_byte(input logic [COV_W-1:0] cov, input logic [ORIGIN_W-1:0] ox,
                            input logic [ORIGIN_W-1:0] oy, input logic [GWIDTH_W-1:0] gw,
                            input logic last);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coverage <= cov;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_glyph_width <= gw;
    in_glyph_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] color, input logic [15:0] fw,
                              input logic [15:0] fh, input logic [15:0] stride);
    write_reg(CFG_TEXT_COLOR, color);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_ROW_STRIDE, stride);
    cfg_wr_en <= 1'b0;
    span_x = (fw[FRAME_W-1:0] > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(fw[FRAME_W-1:0]);
    span_y = (fh[FRAME_W-1:0] > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(fh[FRAME_W-1:0]);
  endtask

  // Stop offering, wait for every expected write, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (writes_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_dim();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(1, 300));
  endfunction

  task automatic configure_phase(input int phase);
    case (phase)
      1: apply_config(16'hFFFF, 16'd4096, 16'd4096, 16'hFFFF);
      2: apply_config(16'h5A31, 16'hFFFF, 16'h1FFF, 16'h0000);
      3: apply_config(16'hABC0, 16'd100, 16'd100, 16'd200);
      4: apply_config(16'hFFF7, 16'd0, 16'd50, 16'd100);
      5: apply_config(16'h123F, 16'd50, 16'd0, 16'd100);
      default: apply_config(16'($urandom), pick_dim(), pick_dim(), 16'($urandom));
    endcase
  endtask

  task automatic directed_bytes();
    // small glyph at the corner: zero, rounding-to-zero and full coverage
    offer_byte(8'd255, 16'd0, 16'd0, 9'd4, 1'b0);
    offer_byte(8'd0,   16'd0, 16'd0, 9'd4, 1'b0);
    offer_byte(8'd1,   16'd0, 16'd0, 9'd4, 1'b0);
    offer_byte(8'd17,  16'd0, 16'd0, 9'd4, 1'b0);
    offer_byte(8'd16,  16'd0, 16'd0, 9'd4, 1'b0);
    offer_byte(8'd128, 16'd0, 16'd0, 9'd4, 1'b0);
    offer_byte(8'd254, 16'd0, 16'd0, 9'd4, 1'b0);
    offer_byte(8'd255, 16'd0, 16'd0, 9'd4, 1'b1);
    // straddle the bottom right corner of the frame
    for (int k = 0; k < 9; k++) offer_byte(8'd255, 16'd1278, 16'd718, 9'd3, k == 8);
    // straddle the top left corner
    for (int k = 0; k < 4; k++) offer_byte(8'd200, 16'hFFFF, 16'hFFFF, 9'd2, k == 3);
    // zero width: every byte starts a new row
    for (int k = 0; k < 3; k++) offer_byte(8'd200, 16'd5, 16'd5, 9'd0, k == 2);
    offer_byte(8'd255, 16'h8000, 16'h7FFF, 9'd511, 1'b1);
  endtask

  // Tall narrow glyph that drives the row counter into saturation
  task automatic tall_glyph(inout int sent);
    logic [ORIGIN_W-1:0] ox;
    ox = 16'($urandom_range(0, 100));
    for (int k = 0; k < 270; k++) offer_byte(pick_coverage(), ox, 16'hFF06, 9'd1, k == 269);
    sent += 270;
  endtask

  task automatic random_glyph(inout int sent, input int quota);
    int                  sel;
    int                  rows;
    int                  cols;
    int                  nbytes;
    bit                  broken;
    logic [GWIDTH_W-1:0] gw;
    logic [ORIGIN_W-1:0] ox;
    logic [ORIGIN_W-1:0] oy;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      gw = 9'd0;
      cols = 1;
      rows = $urandom_range(1, 6);
    end else if (sel < 10) begin
      gw = 9'($urandom_range(256, 511));
      cols = MAX_GLYPH_SIZE;
      rows = 1;
    end else if (sel < 15) begin
      gw = 9'($urandom_range(13, 255));
      cols = int'(gw);
      rows = $urandom_range(1, 2);
    end else begin
      gw = 9'($urandom_range(1, 12));
      cols = int'(gw);
      rows = $urandom_range(1, 10);
    end
    ox = pick_origin(span_x);
    oy = pick_origin(span_y);
    nbytes = cols * rows;
    // cut the glyph short at the end of the phase's share
    if (nbytes > quota - sent) nbytes = quota - sent;
    broken = ($urandom_range(0, 99) < 8);
    for (int k = 0; k < nbytes; k++) begin
      if (broken && $urandom_range(0, 99) < 30)
        offer_byte(8'($urandom), 16'($urandom), 16'($urandom), 9'($urandom),
                   (k == nbytes - 1) || ($urandom_range(0, 99) < 5));
      else
        offer_byte(pick_coverage(), ox, oy, gw, k == nbytes - 1);
    end
    sent += nbytes;
  endtask

  initial begin : stimulus
    int sent;
    int quota;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        configure_phase(phase);
      end
      calm = (phase == 1) || (phase == 8);
      sent = 0;
      quota = (phase >= 3 && phase <= 5) ? 50 : 160;
      if (phase == 0) directed_bytes();
      if (phase == 1) begin
        // hold the output while bytes keep coming, so the queue fills and in_stall rises
        hold_trigger = 1'b1;
        tall_glyph(sent);
      end
      while (sent < quota) random_glyph(sent, quota);
    end
    drain();
    if (fail_count == 0) begin
      $display("tb_glyph_coverage_blitter_unit OK");
    end else begin
      $display("tb_glyph_coverage_blitter_unit NOT OK");
    end
    $finish;
  end

endmodule
